// ===== hw/rtl/tlv_field_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// TLV field extractor assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TLV_FIELD_EXTRACTOR_ASSERT_SVH
`define TLV_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLV_FE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLV_FE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlv_fe_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV field extractor package
// Shared types, codes and constants of the TLV field extractor.
// ----------------------------------------------------------------------------
package tlv_fe_pkg;

  // Default number of value bytes gathered into the integer.
  localparam int unsigned IntBytesDefault = 8;
  // Width of the integer result.
  localparam int unsigned IntW = 64;
  // Output queue depth; two free entries are needed to take a transfer.
  localparam int unsigned QueueDepth = 4;
  // Configuration port widths.
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;
  // Output tdata width: 92 payload bits padded to whole bytes.
  localparam int unsigned OutDataW = 96;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TARGET_TAG = 1'b0,
    CFG_VALUE_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_SHORT     = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_VALUE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e              record_kind;
    logic [7:0]         value_byte;
    status_e            status;
    logic [15:0]        value_length;
    logic signed [IntW-1:0] value_int;
    logic               value_valid;
  } result_t;

  // Results produced by one accepted input transfer, in delivery order.
  typedef struct packed {
    logic    byte_vld;
    logic    sum_vld;
    result_t byte_res;
    result_t sum_res;
  } push_t;

endpackage

// ===== hw/rtl/tlv_fe_walker.sv =====
// ----------------------------------------------------------------------------
// TLV field extractor record walker
// Holds the header, skip and value state of the record chain and forms the
// value-byte and summary results of each accepted byte.
// ----------------------------------------------------------------------------
module tlv_fe_walker #(
  parameter int unsigned IntBytes = tlv_fe_pkg::IntBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [15:0]         target_tag_i,
  input  logic                value_mode_i,
  output tlv_fe_pkg::push_t   push_o
);

  localparam int unsigned TakenW = $clog2(IntBytes + 1);
  localparam int unsigned IntW   = tlv_fe_pkg::IntW;

  tlv_fe_pkg::phase_e phase_q, phase_d;
  logic [23:0]        hdr_shift_q, hdr_shift_d;
  logic [1:0]         hdr_count_q, hdr_count_d;
  logic [15:0]        bytes_left_q, bytes_left_d;
  logic               found_q, found_d;
  logic [15:0]        mlen_q, mlen_d;
  logic [IntW-1:0]    acc_q, acc_d;
  logic [TakenW-1:0]  taken_q, taken_d;
  logic [2:0]         short_q, short_d;

  logic [15:0]        hdr_tag;
  logic [15:0]        hdr_len;
  tlv_fe_pkg::status_e sum_status;

  // Sign-extend the gathered integer from its byte count; a full word stays.
  function automatic logic [IntW-1:0] sign_ext(logic [IntW-1:0] v,
                                               logic [TakenW-1:0] n);
    logic [IntW-1:0] res;
    res = v;
    for (int k = 1; k < 8; k++) begin
      if (int'(n) == k) begin
        for (int i = 0; i < IntW; i++) begin
          if (i >= k * 8) begin
            res[i] = v[k*8-1];
          end else begin
            res[i] = v[i];
          end
        end
      end
    end
    return res;
  endfunction

  assign hdr_tag = hdr_shift_q[23:8];
  assign hdr_len = {hdr_shift_q[7:0], data_byte_i};

  // Next state and results of the byte at the input.
  always_comb begin
    phase_d      = phase_q;
    hdr_shift_d  = hdr_shift_q;
    hdr_count_d  = hdr_count_q;
    bytes_left_d = bytes_left_q;
    found_d      = found_q;
    mlen_d       = mlen_q;
    acc_d        = acc_q;
    taken_d      = taken_q;
    sum_status   = tlv_fe_pkg::ST_NOT_FOUND;
    push_o       = '0;

    // Buffer length counter saturates once a full header fits.
    short_d = (short_q < 3'd4) ? short_q + 3'd1 : short_q;

    case (phase_q)
      tlv_fe_pkg::PH_HEADER: begin
        if (hdr_count_q != 2'd3) begin
          hdr_shift_d = {hdr_shift_q[15:0], data_byte_i};
          hdr_count_d = hdr_count_q + 2'd1;
        end else begin
          hdr_shift_d  = '0;
          hdr_count_d  = '0;
          bytes_left_d = hdr_len;
          if (hdr_tag == target_tag_i) begin
            found_d = 1'b1;
            mlen_d  = hdr_len;
            phase_d = (hdr_len != 16'd0) ? tlv_fe_pkg::PH_VALUE : tlv_fe_pkg::PH_DONE;
          end else begin
            phase_d = (hdr_len != 16'd0) ? tlv_fe_pkg::PH_SKIP : tlv_fe_pkg::PH_HEADER;
          end
        end
      end
      tlv_fe_pkg::PH_SKIP: begin
        bytes_left_d = bytes_left_q - 16'd1;
        if (bytes_left_d == 16'd0) begin
          phase_d = tlv_fe_pkg::PH_HEADER;
        end
      end
      tlv_fe_pkg::PH_VALUE: begin
        if (taken_q < TakenW'(IntBytes)) begin
          acc_d   = {acc_q[IntW-9:0], data_byte_i};
          taken_d = taken_q + TakenW'(1);
        end
        if (!value_mode_i) begin
          push_o.byte_vld                 = accept_i;
          push_o.byte_res.record_kind     = tlv_fe_pkg::KIND_VALUE;
          push_o.byte_res.value_byte      = data_byte_i;
          push_o.byte_res.status          = tlv_fe_pkg::ST_FOUND;
          push_o.byte_res.value_length    = mlen_q;
        end
        bytes_left_d = bytes_left_q - 16'd1;
        if (bytes_left_d == 16'd0) begin
          phase_d = tlv_fe_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // End-of-buffer summary, then a fresh walk.
    if (last_byte_i) begin
      if (short_d < 3'd4) begin
        sum_status = tlv_fe_pkg::ST_SHORT;
      end else if (found_d) begin
        sum_status = (phase_d == tlv_fe_pkg::PH_VALUE) ? tlv_fe_pkg::ST_TRUNCATED
                                                       : tlv_fe_pkg::ST_FOUND;
      end else if (phase_d == tlv_fe_pkg::PH_SKIP) begin
        sum_status = tlv_fe_pkg::ST_OVERRUN;
      end else begin
        sum_status = tlv_fe_pkg::ST_NOT_FOUND;
      end

      push_o.sum_vld              = accept_i;
      push_o.sum_res.record_kind  = tlv_fe_pkg::KIND_SUMMARY;
      push_o.sum_res.value_byte   = '0;
      push_o.sum_res.status       = sum_status;
      push_o.sum_res.value_length = found_d ? mlen_d : 16'd0;
      if (sum_status == tlv_fe_pkg::ST_FOUND && value_mode_i && taken_d != '0) begin
        push_o.sum_res.value_int   = sign_ext(acc_d, taken_d);
        push_o.sum_res.value_valid = 1'b1;
      end

      phase_d      = tlv_fe_pkg::PH_HEADER;
      hdr_shift_d  = '0;
      hdr_count_d  = '0;
      bytes_left_d = '0;
      found_d      = 1'b0;
      mlen_d       = '0;
      acc_d        = '0;
      taken_d      = '0;
      short_d      = '0;
    end
  end

  // Walk state advances on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tlv_fe_pkg::PH_HEADER;
      hdr_shift_q  <= '0;
      hdr_count_q  <= '0;
      bytes_left_q <= '0;
      found_q      <= 1'b0;
      mlen_q       <= '0;
      acc_q        <= '0;
      taken_q      <= '0;
      short_q      <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      hdr_shift_q  <= hdr_shift_d;
      hdr_count_q  <= hdr_count_d;
      bytes_left_q <= bytes_left_d;
      found_q      <= found_d;
      mlen_q       <= mlen_d;
      acc_q        <= acc_d;
      taken_q      <= taken_d;
      short_q      <= short_d;
    end
  end

endmodule

// ===== hw/rtl/tlv_fe_outq.sv =====
// ----------------------------------------------------------------------------
// TLV field extractor result queue
// Small register queue that takes up to two results per cycle and hands
// out one per output transfer.
// ----------------------------------------------------------------------------
module tlv_fe_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlv_fe_pkg::push_t   push_i,
  input  logic                pop_i,
  output tlv_fe_pkg::result_t head_o,
  output logic                valid_o,
  output logic                ready_o
);

  localparam int unsigned Depth = tlv_fe_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tlv_fe_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [PtrW-1:0]     sum_ptr;
  logic [CntW-1:0]     n_push;

  // The summary lands behind the value byte when both arrive together.
  assign sum_ptr = wr_ptr_q + PtrW'(push_i.byte_vld);
  assign n_push  = CntW'(push_i.byte_vld) + CntW'(push_i.sum_vld);

  assign wr_ptr_d = wr_ptr_q + PtrW'(n_push);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
  assign count_d  = count_q + n_push - CntW'(pop_i);

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign ready_o = (count_q <= CntW'(Depth - 2));

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.byte_vld) begin
      mem_q[wr_ptr_q] <= push_i.byte_res;
    end
    if (push_i.sum_vld) begin
      mem_q[sum_ptr] <= push_i.sum_res;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/tlv_field_extractor.sv =====
// ----------------------------------------------------------------------------
// TLV field extractor: one byte per cycle while the queue has room; results are registered.
// The walk state updates in the accepting cycle; a 4-entry queue buffers results.
// A last byte with a value byte makes two results; input stalls only on queue space.
// Reset (async, low) clears the walk and both registers to zero and empties the queue.
// ----------------------------------------------------------------------------
module tlv_field_extractor #(
  parameter int unsigned IntBytes = tlv_fe_pkg::IntBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [tlv_fe_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [tlv_fe_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input byte stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tlast,  // last_byte
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] value_byte, [10:8] status, [26:11] value_length,
  // [90:27] value_int, [91] value_valid, [95:92] zero
  output logic [tlv_fe_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser   // record_kind
);

  logic [15:0]         target_tag_q;
  logic                value_mode_q;
  logic                in_accept;
  logic                out_pop;
  tlv_fe_pkg::push_t   push;
  tlv_fe_pkg::result_t head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q <= '0;
      value_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (tlv_fe_pkg::cfg_idx_e'(cfg_addr_i))
        tlv_fe_pkg::CFG_TARGET_TAG: target_tag_q <= cfg_wdata_i[15:0];
        tlv_fe_pkg::CFG_VALUE_MODE: value_mode_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_pop   = m_axis_tvalid && m_axis_tready;

  tlv_fe_walker #(
    .IntBytes(IntBytes)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .target_tag_i(target_tag_q),
    .value_mode_i(value_mode_q),
    .push_o      (push)
  );

  tlv_fe_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_pop),
    .head_o (head),
    .valid_o(m_axis_tvalid),
    .ready_o(s_axis_tready)
  );

  // Pack the head result onto the output bus.
  assign m_axis_tdata = {4'b0000, head.value_valid, head.value_int, head.value_length,
                         head.status, head.value_byte};
  assign m_axis_tuser = head.record_kind;

endmodule

// ===== hw/rtl/tlv_fe_checker.sv =====
// ----------------------------------------------------------------------------
// TLV field extractor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "tlv_field_extractor_assert.svh"

module tlv_fe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tlv_fe_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  // A stalled result holds its contents.
  `TLV_FE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // The last byte of a buffer always yields a result in the next cycle.
  `TLV_FE_ASSERT_NXT(a_last_gives_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no result after last byte")

  // Value-byte results carry a found status and no integer.
  `TLV_FE_ASSERT_IMP(a_byte_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == tlv_fe_pkg::KIND_VALUE, m_axis_tdata[10:8] == tlv_fe_pkg::ST_FOUND && m_axis_tdata[91:27] == '0, "value byte result not clean")

  // An integer is only reported with a found status.
  `TLV_FE_ASSERT_IMP(a_int_found, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[91], m_axis_tuser == tlv_fe_pkg::KIND_SUMMARY && m_axis_tdata[10:8] == tlv_fe_pkg::ST_FOUND, "integer without found status")

endmodule

bind tlv_field_extractor tlv_fe_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
